FILE: rtl/hs_pkg.sv
package hs_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_BUILD_RD,
        S_BUILD_LD,
        S_SIFT_RL,
        S_SIFT_RR,
        S_SIFT_CMP,
        S_SORT_RD0,
        S_SORT_RDI,
        S_SORT_SW,
        S_OUT_RD,
        S_OUT_LD
    } t_state;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_STORE,
        OP_BUILD_INIT,
        OP_BUILD_RD,
        OP_BUILD_LD,
        OP_SIFT_RL,
        OP_SIFT_RR,
        OP_SIFT_CMP,
        OP_SORT_RD0,
        OP_SORT_RDI,
        OP_SORT_SW,
        OP_OUT_RD,
        OP_OUT_LD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic idx_dec;
        logic sort_init;
        logic out_init;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic count_nz;
        logic left_in;
        logic child_wins;
        logic idx_zero;
        logic idx_one;
        logic out_free;
        logic out_last;
    } t_status;

endpackage

FILE: rtl/hs_ctrl.sv
module hs_ctrl
    import hs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_sorting;
    logic   n_sorting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_sorting <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sorting <= n_sorting;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_sorting      = r_sorting;
        o_in_ready     = 1'b0;
        o_cmd.op       = OP_IDLE;
        o_cmd.idx_dec  = 1'b0;
        o_cmd.sort_init = 1'b0;
        o_cmd.out_init = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.op = OP_STORE;
                    if (i_in_last) begin
                        if (i_st.full || i_st.count_nz) begin
                            n_state = S_INIT;
                        end else begin
                            o_cmd.out_init = 1'b1;
                            n_state        = S_OUT_RD;
                        end
                    end
                end
            end
            S_INIT: begin
                o_cmd.op  = OP_BUILD_INIT;
                n_sorting = 1'b0;
                n_state   = S_BUILD_RD;
            end
            S_BUILD_RD: begin
                o_cmd.op = OP_BUILD_RD;
                n_state  = S_BUILD_LD;
            end
            S_BUILD_LD: begin
                o_cmd.op = OP_BUILD_LD;
                n_state  = S_SIFT_RL;
            end
            S_SIFT_RL, S_SIFT_CMP: begin
                o_cmd.op = (r_state == S_SIFT_RL) ? OP_SIFT_RL : OP_SIFT_CMP;
                if (r_state == S_SIFT_RL && i_st.left_in) begin
                    n_state = S_SIFT_RR;
                end else if (r_state == S_SIFT_CMP && i_st.child_wins) begin
                    n_state = S_SIFT_RL;
                end else if (!r_sorting) begin
                    if (i_st.idx_zero) begin
                        o_cmd.sort_init = 1'b1;
                        n_sorting       = 1'b1;
                        n_state         = S_SORT_RD0;
                    end else begin
                        o_cmd.idx_dec = 1'b1;
                        n_state       = S_BUILD_RD;
                    end
                end else begin
                    if (i_st.idx_one) begin
                        o_cmd.out_init = 1'b1;
                        n_sorting      = 1'b0;
                        n_state        = S_OUT_RD;
                    end else begin
                        o_cmd.idx_dec = 1'b1;
                        n_state       = S_SORT_RD0;
                    end
                end
            end
            S_SIFT_RR: begin
                o_cmd.op = OP_SIFT_RR;
                n_state  = S_SIFT_CMP;
            end
            S_SORT_RD0: begin
                o_cmd.op = OP_SORT_RD0;
                n_state  = S_SORT_RDI;
            end
            S_SORT_RDI: begin
                o_cmd.op = OP_SORT_RDI;
                n_state  = S_SORT_SW;
            end
            S_SORT_SW: begin
                o_cmd.op = OP_SORT_SW;
                n_state  = S_SIFT_RL;
            end
            S_OUT_RD: begin
                o_cmd.op = OP_OUT_RD;
                n_state  = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.op = OP_OUT_LD;
                if (i_st.out_free) begin
                    n_state = i_st.out_last ? S_LOAD : S_OUT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/hs_datapath.sv
module hs_datapath
    import hs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_st,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_out_value,
    output logic              o_out_final,
    output logic              o_out_ovf
);

    logic signed [DATA_W-1:0] r_mem [CAPACITY];
    logic signed [DATA_W-1:0] r_rd_data;
    logic signed [DATA_W-1:0] r_v;
    logic signed [DATA_W-1:0] r_left;
    logic signed [DATA_W-1:0] r_top;
    logic [CNT_W-1:0]         r_count;
    logic                     r_drop;
    logic [ADDR_W-1:0]        r_idx;
    logic [ADDR_W-1:0]        r_pos;
    logic [CNT_W-1:0]         r_len;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_value;
    logic                     r_out_final;
    logic                     r_out_ovf;

    logic [CHILD_W-1:0]       left_idx;
    logic [CHILD_W-1:0]       right_idx;
    logic                     left_in;
    logic                     right_in;
    logic                     left_wins;
    logic signed [DATA_W-1:0] big_val;
    logic                     right_wins;
    logic                     child_wins;
    logic                     out_free;
    logic                     out_last;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [CNT_W-1:0]         idx_ext;

    assign left_idx   = {r_pos, 1'b1};
    assign right_idx  = left_idx + CHILD_W'(1);
    assign left_in    = left_idx < r_len;
    assign right_in   = right_idx < r_len;
    assign left_wins  = r_left > r_v;
    assign big_val    = left_wins ? r_left : r_v;
    assign right_wins = right_in && (r_rd_data > big_val);
    assign child_wins = left_wins || right_wins;
    assign out_free   = !r_out_valid || i_out_ready;
    assign idx_ext    = {1'b0, r_idx};
    assign out_last   = (idx_ext + CNT_W'(1)) == r_count;

    assign o_st.full       = r_count == CNT_W'(CAPACITY);
    assign o_st.count_nz   = r_count != '0;
    assign o_st.left_in    = left_in;
    assign o_st.child_wins = child_wins;
    assign o_st.idx_zero   = r_idx == '0;
    assign o_st.idx_one    = r_idx == ADDR_W'(1);
    assign o_st.out_free   = out_free;
    assign o_st.out_last   = out_last;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = r_v;
        case (i_cmd.op)
            OP_STORE: begin
                wr_en   = r_count < CNT_W'(CAPACITY);
                wr_addr = r_count[ADDR_W-1:0];
                wr_data = i_value;
            end
            OP_BUILD_RD, OP_OUT_RD: begin
                rd_en = 1'b1;
            end
            OP_SIFT_RL: begin
                if (left_in) begin
                    rd_en   = 1'b1;
                    rd_addr = left_idx[ADDR_W-1:0];
                end else begin
                    wr_en = 1'b1;
                end
            end
            OP_SIFT_RR: begin
                rd_en   = 1'b1;
                rd_addr = right_idx[ADDR_W-1:0];
            end
            OP_SIFT_CMP: begin
                wr_en = 1'b1;
                if (child_wins) begin
                    wr_data = right_wins ? r_rd_data : r_left;
                end
            end
            OP_SORT_RD0: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            OP_SORT_RDI: begin
                rd_en = 1'b1;
            end
            OP_SORT_SW: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = r_top;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_BUILD_LD: begin
                r_v   <= r_rd_data;
                r_pos <= r_idx;
            end
            OP_SIFT_RR: begin
                r_left <= r_rd_data;
            end
            OP_SIFT_CMP: begin
                if (child_wins) begin
                    r_pos <= right_wins ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
                end
            end
            OP_SORT_RDI: begin
                r_top <= r_rd_data;
            end
            OP_SORT_SW: begin
                r_v   <= r_rd_data;
                r_pos <= '0;
                r_len <= idx_ext;
            end
            OP_BUILD_INIT: begin
                r_len <= r_count;
            end
            default: begin
                r_len <= r_len;
            end
        endcase
        if (i_cmd.op == OP_OUT_LD && out_free) begin
            r_out_value <= r_rd_data;
            r_out_final <= out_last;
            r_out_ovf   <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_STORE) begin
                if (r_count < CNT_W'(CAPACITY)) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.op == OP_BUILD_INIT) begin
                r_idx <= ADDR_W'((r_count - CNT_W'(2)) >> 1);
            end else if (i_cmd.sort_init) begin
                r_idx <= ADDR_W'(r_count - CNT_W'(1));
            end else if (i_cmd.out_init) begin
                r_idx <= '0;
            end else if (i_cmd.idx_dec) begin
                r_idx <= r_idx - ADDR_W'(1);
            end else if (i_cmd.op == OP_OUT_LD && out_free && !out_last) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
            if (i_cmd.op == OP_OUT_LD && out_free) begin
                r_out_valid <= 1'b1;
                if (out_last) begin
                    r_count <= '0;
                    r_drop  <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_final = r_out_final;
    assign o_out_ovf   = r_out_ovf;

endmodule

FILE: rtl/heap_sorter_top.sv
// Loading accepts one input word per cycle; the store holds up to 64 words. After
// the word marked last, a max-heap is built and sorted in place by one sift unit on
// a single-port memory (a one-word set skips the sort). A sift level reads both
// children, then compares; a sort pass reads the root and the last word, then swaps.
// Results leave one by one, each held while stalled. Synchronous active-low reset
// empties the set and the output register; the store itself is not cleared.
module heap_sorter_top
    import hs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] overflow
);

    t_cmd    cmd;
    t_status st;

    hs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    hs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_value     (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_value (m_axis_tdata),
        .o_out_final (m_axis_tlast),
        .o_out_ovf   (m_axis_tuser)
    );

endmodule

FILE: rtl/hs_checker.sv
module hs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // A result that is not the last of its set means the sort is still emitting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken while a set is still being emitted");

    // The word that closes a set starts the sort (or, for a one-word set, the output), so input stalls next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after the last word of a set");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word withdrawn before it was taken");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

endmodule

bind heap_sorter_top hs_checker u_hs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
